[src/stick_axis_deadzone_normalizer_macros.svh]
// Assertion helpers shared by the normaliser RTL.
`ifndef STICK_AXIS_DEADZONE_NORMALIZER_MACROS_SVH
`define STICK_AXIS_DEADZONE_NORMALIZER_MACROS_SVH

// Same-cycle (or delayed via a ## sequence) implication.
`define SADN_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sadn assertion failed");

// Next-cycle implication.
`define SADN_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sadn assertion failed");

`endif

[src/sadn_pkg.sv]
package sadn_pkg;

   localparam int SADN_SAMPLE_W = 16;
   localparam int SADN_DZ_W     = 15;
   localparam int SADN_GAIN_W   = 16;
   localparam int SADN_OUT_W    = 20;
   localparam int SADN_WIDE_W   = 18;   // signed edges and spans
   localparam int SADN_NUM_W    = 16;   // magnitude of the excess
   localparam int SADN_DEN_W    = 17;   // magnitude of the span
   localparam int SADN_QUOT_BITS = 14;  // fractional quotient bits, one per cell
   localparam int SADN_QMAG_W   = SADN_QUOT_BITS + 1;
   localparam int SADN_PROD_W   = SADN_QMAG_W + SADN_GAIN_W;
   localparam int SADN_GAIN_FRAC = 12;
   localparam int SADN_CSR_IDX_W = 3;

   // Clamp, branch select, span/saturation, one cell per quotient bit,
   // multiply, output register.
   localparam int SADN_LATENCY = 3 + SADN_QUOT_BITS + 2;

   localparam logic [SADN_QMAG_W-1:0] SADN_Q14_ONE = SADN_QMAG_W'(16384);

   typedef enum logic [SADN_CSR_IDX_W-1:0] {
      CSR_RAW_MINIMUM  = 3'd0,
      CSR_RAW_MAXIMUM  = 3'd1,
      CSR_TRIM_CENTER  = 3'd2,
      CSR_DEAD_ZONE    = 3'd3,
      CSR_REVERSE_AXIS = 3'd4,
      CSR_GAIN         = 3'd5
   } sadn_csr_index_type;

   typedef struct packed {
      logic signed [SADN_SAMPLE_W-1:0] raw_minimum;
      logic signed [SADN_SAMPLE_W-1:0] raw_maximum;
      logic signed [SADN_SAMPLE_W-1:0] trim_center;
      logic        [SADN_DZ_W-1:0]     dead_zone;
      logic                            reverse_axis;
      logic        [SADN_GAIN_W-1:0]   gain;
   } sadn_cfg_type;

   // One beat travelling down the divider row.
   typedef struct packed {
      logic                      valid;
      logic                      neg;    // sign of the quotient
      logic                      sat;    // magnitude pinned at 1.0
      logic                      zero;   // inside the dead band
      logic [SADN_DEN_W-1:0]     rem;
      logic [SADN_DEN_W-1:0]     dvs;
      logic [SADN_QUOT_BITS-1:0] quot;
   } sadn_beat_type;

endpackage

[src/stick_axis_deadzone_normalizer.sv]
// A sample taken at a start edge passes 3 front stages, 14 divider cells and 2 output stages,
//   then appears on rsp_scaled_value with rsp_strobe.
// Throughput: one sample per cycle; busy is low except during reset.
// The receiver cannot stall; every beat is dropped after its single strobe cycle.
// Reset (synchronous, active high) empties the pipeline and restores all configuration registers
//   to their defaults: full-range bounds, zero trim and dead zone, no reversal, gain 1.0.
`include "stick_axis_deadzone_normalizer_macros.svh"

module stick_axis_deadzone_normalizer (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   output logic                                          busy,
   input  logic signed [sadn_pkg::SADN_SAMPLE_W-1:0]     req_raw_sample,
   output logic                                          rsp_strobe,
   output logic signed [sadn_pkg::SADN_OUT_W-1:0]        rsp_scaled_value,
   input  logic                                          csr_write_enable,
   input  logic [sadn_pkg::SADN_CSR_IDX_W-1:0]           csr_index,
   input  logic [sadn_pkg::SADN_SAMPLE_W-1:0]            csr_write_data
);

   localparam int QB = sadn_pkg::SADN_QUOT_BITS;

   sadn_pkg::sadn_cfg_type  cfg_ff, cfg_in;
   sadn_pkg::sadn_beat_type chain [QB+1];
   logic                    accept;
   logic                    rsp_in_range;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (sadn_pkg::sadn_csr_index_type'(csr_index))
            sadn_pkg::CSR_RAW_MINIMUM: begin
               cfg_in.raw_minimum = $signed(csr_write_data);
            end
            sadn_pkg::CSR_RAW_MAXIMUM: begin
               cfg_in.raw_maximum = $signed(csr_write_data);
            end
            sadn_pkg::CSR_TRIM_CENTER: begin
               cfg_in.trim_center = $signed(csr_write_data);
            end
            sadn_pkg::CSR_DEAD_ZONE: begin
               cfg_in.dead_zone = csr_write_data[sadn_pkg::SADN_DZ_W-1:0];
            end
            sadn_pkg::CSR_REVERSE_AXIS: begin
               cfg_in.reverse_axis = csr_write_data[0];
            end
            sadn_pkg::CSR_GAIN: begin
               cfg_in.gain = csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_minimum  <= 16'sh8000;
         cfg_ff.raw_maximum  <= 16'sh7FFF;
         cfg_ff.trim_center  <= '0;
         cfg_ff.dead_zone    <= '0;
         cfg_ff.reverse_axis <= 1'b0;
         cfg_ff.gain         <= 16'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sadn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .raw_sample (req_raw_sample),
      .cfg        (cfg_ff),
      .beat_o     (chain[0])
   );

   // one quotient bit per cell
   for (genvar i = 0; i < QB; i++) begin : g_cell
      sadn_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .beat_i (chain[i]),
         .beat_o (chain[i+1])
      );
   end

   sadn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .beat_i       (chain[QB]),
      .cfg          (cfg_ff),
      .strobe       (rsp_strobe),
      .scaled_value (rsp_scaled_value)
   );

   assign rsp_in_range = (rsp_scaled_value <= 20'sd262144) &&
                         (rsp_scaled_value >= -20'sd262144);

   `SADN_ASSERT_IMPLY(a_rsp_latency, clock, reset, accept, ##(sadn_pkg::SADN_LATENCY) rsp_strobe)
   `SADN_ASSERT_IMPLY(a_no_spurious, clock, reset, !accept, ##(sadn_pkg::SADN_LATENCY) !rsp_strobe)
   `SADN_ASSERT_IMPLY(a_rsp_range, clock, reset, rsp_strobe, rsp_in_range)

endmodule

[src/sadn_front.sv]
module sadn_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic signed [sadn_pkg::SADN_SAMPLE_W-1:0] raw_sample,
   input  sadn_pkg::sadn_cfg_type                cfg,
   output sadn_pkg::sadn_beat_type               beat_o
);

   localparam int WW = sadn_pkg::SADN_WIDE_W;

   // stage A: clamped sample
   logic                                      a_valid_ff;
   logic signed [sadn_pkg::SADN_SAMPLE_W-1:0] xc_ff, xc_in;

   // stage B: branch, excess magnitude, signed span
   logic                                   b_valid_ff;
   logic                                   b_active_ff, b_active_in;
   logic                                   b_neg_ff, b_neg_in;
   logic [sadn_pkg::SADN_NUM_W-1:0]        b_num_ff, b_num_in;
   logic signed [WW-1:0]                   b_den_ff, b_den_in;

   // stage C: beat into the divider row
   sadn_pkg::sadn_beat_type beat_ff, beat_in;

   logic signed [WW-1:0] x_w, tc_w, dz_w, min_w, max_w;
   logic signed [WW-1:0] hi_edge, lo_edge, num_w;
   logic                 up, dn;
   logic                 den_neg;
   logic [WW-1:0]        den_abs;
   logic [sadn_pkg::SADN_DEN_W-1:0] den_mag;
   logic                 sat;

   // Raise to the minimum first, then lower to the maximum.
   always_comb begin
      xc_in = raw_sample;
      if (raw_sample < cfg.raw_minimum) begin
         xc_in = cfg.raw_minimum;
      end
      if (xc_in > cfg.raw_maximum) begin
         xc_in = cfg.raw_maximum;
      end
   end

   always_comb begin
      x_w     = WW'(xc_ff);
      tc_w    = WW'(cfg.trim_center);
      dz_w    = $signed({{(WW - sadn_pkg::SADN_DZ_W){1'b0}}, cfg.dead_zone});
      min_w   = WW'(cfg.raw_minimum);
      max_w   = WW'(cfg.raw_maximum);
      hi_edge = tc_w + dz_w;
      lo_edge = tc_w - dz_w;
      up      = x_w > hi_edge;
      dn      = x_w < lo_edge;
      num_w   = up ? (x_w - hi_edge) : (lo_edge - x_w);
      b_num_in    = num_w[sadn_pkg::SADN_NUM_W-1:0];
      b_den_in    = up ? (max_w - hi_edge) : (lo_edge - min_w);
      b_active_in = up || dn;
      b_neg_in    = !up;
   end

   always_comb begin
      den_neg = b_den_ff[WW-1];
      den_abs = den_neg ? WW'(-b_den_ff) : WW'(b_den_ff);
      den_mag = den_abs[sadn_pkg::SADN_DEN_W-1:0];
      // quotient reaches 1.0 once the excess is at least the span
      sat     = (den_mag == '0) ||
                ({1'b0, b_num_ff} >= den_mag);
      beat_in.valid = b_valid_ff;
      beat_in.neg   = b_neg_ff ^ (den_neg && (den_mag != '0));
      beat_in.sat   = sat;
      beat_in.zero  = !b_active_ff;
      beat_in.rem   = sat ? '0 : {1'b0, b_num_ff};
      beat_in.dvs   = den_mag;
      beat_in.quot  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         beat_ff    <= '0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         beat_ff    <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      xc_ff       <= xc_in;
      b_active_ff <= b_active_in;
      b_neg_ff    <= b_neg_in;
      b_num_ff    <= b_num_in;
      b_den_ff    <= b_den_in;
   end

   assign beat_o = beat_ff;

endmodule

[src/sadn_div_cell.sv]
`include "stick_axis_deadzone_normalizer_macros.svh"

module sadn_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  sadn_pkg::sadn_beat_type beat_i,
   output sadn_pkg::sadn_beat_type beat_o
);

   localparam int DW = sadn_pkg::SADN_DEN_W;
   localparam int QB = sadn_pkg::SADN_QUOT_BITS;

   sadn_pkg::sadn_beat_type beat_ff, beat_in;

   logic [DW:0] rem2;
   logic [DW:0] diff;
   logic        ge;
   logic        live_div;

   // One restoring step: double the remainder, subtract the divisor if it fits.
   always_comb begin
      rem2 = {beat_i.rem, 1'b0};
      diff = rem2 - {1'b0, beat_i.dvs};
      ge   = rem2 >= {1'b0, beat_i.dvs};
      beat_in      = beat_i;
      beat_in.rem  = ge ? diff[DW-1:0] : rem2[DW-1:0];
      beat_in.quot = {beat_i.quot[QB-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

   assign live_div = beat_i.valid && !beat_i.sat && !beat_i.zero &&
                     (beat_i.rem < beat_i.dvs);

   // remainder stays below the divisor on a live division
   `SADN_ASSERT_NEXT(a_rem_below_dvs, clock, reset, live_div, beat_ff.rem < beat_ff.dvs)
   `SADN_ASSERT_IMPLY(a_sat_rem_clear, clock, reset, beat_ff.valid && beat_ff.sat, beat_ff.rem == '0)

endmodule

[src/sadn_back.sv]
module sadn_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sadn_pkg::sadn_beat_type                beat_i,
   input  sadn_pkg::sadn_cfg_type                 cfg,
   output logic                                   strobe,
   output logic signed [sadn_pkg::SADN_OUT_W-1:0] scaled_value
);

   localparam int QW = sadn_pkg::SADN_QMAG_W;
   localparam int PW = sadn_pkg::SADN_PROD_W;
   localparam int OW = sadn_pkg::SADN_OUT_W;
   localparam int FR = sadn_pkg::SADN_GAIN_FRAC;

   logic                 m_valid_ff;
   logic                 m_neg_ff, m_neg_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [QW-1:0]        qmag;

   logic                 o_valid_ff;
   logic signed [OW-1:0] out_ff, out_in;
   logic [OW-1:0]        mag_w;

   always_comb begin
      if (beat_i.zero) begin
         qmag = '0;
      end else if (beat_i.sat) begin
         qmag = sadn_pkg::SADN_Q14_ONE;
      end else begin
         qmag = {1'b0, beat_i.quot};
      end
      prod_in  = PW'(qmag) * PW'(cfg.gain);
      m_neg_in = beat_i.neg ^ cfg.reverse_axis;
   end

   // Truncate toward zero: shift the magnitude, then apply the sign.
   always_comb begin
      mag_w  = OW'(prod_ff[PW-1:FR]);
      out_in = m_neg_ff ? -$signed(mag_w) : $signed(mag_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= beat_i.valid;
         o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_neg_ff <= m_neg_in;
      prod_ff  <= prod_in;
      out_ff   <= out_in;
   end

   assign strobe       = o_valid_ff;
   assign scaled_value = out_ff;

endmodule

[dv/testbench.sv]
module testbench;
   import sadn_pkg::*;

   localparam longint UNITY_Q14 = 16384;
   localparam longint UNITY_Q12 = 4096;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 50;

   localparam logic [SADN_CSR_IDX_W-1:0] CSR_SPARE_SIX   = 3'd6;
   localparam logic [SADN_CSR_IDX_W-1:0] CSR_SPARE_SEVEN = 3'd7;
   localparam logic [SADN_CSR_IDX_W-1:0] NO_INDEX        = '0;

   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [SADN_CSR_IDX_W-1:0]      index;
      logic [SADN_SAMPLE_W-1:0]       value;   // register data or raw sample
      bit                             checked; // want holds the typed-in result
      logic signed [SADN_OUT_W-1:0]   want;
   } dir_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic signed [SADN_SAMPLE_W-1:0]  req_raw_sample = '0;
   logic                             rsp_strobe;
   logic signed [SADN_OUT_W-1:0]     rsp_scaled_value;
   logic                             csr_write_enable = 1'b0;
   logic [SADN_CSR_IDX_W-1:0]        csr_index = '0;
   logic [SADN_SAMPLE_W-1:0]         csr_write_data = '0;

   // Register values as the block should currently hold them
   logic signed [SADN_SAMPLE_W-1:0]  cfg_raw_min;
   logic signed [SADN_SAMPLE_W-1:0]  cfg_raw_max;
   logic signed [SADN_SAMPLE_W-1:0]  cfg_trim;
   logic [SADN_DZ_W-1:0]             cfg_dead_zone;
   logic                             cfg_reverse;
   logic [SADN_GAIN_W-1:0]           cfg_gain;

   logic signed [SADN_OUT_W-1:0]     pending_scaled[$];
   int                               mismatches = 0;
   int unsigned                      cycle_count = 0;

   dir_row_type directed_rows[$] = '{
      '{ROW_SAMPLE, NO_INDEX, 16'd0,          1'b1, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h7FFF,       1'b1, 20'sd16384},
      '{ROW_SAMPLE, NO_INDEX, 16'h8000,       1'b1, 20'(-16384)},
      '{ROW_SAMPLE, NO_INDEX, 16'd1,          1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'hFFFF,       1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'd16384,      1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'(-12345),    1'b0, 20'sd0},
      // zero gain
      '{ROW_WRITE,  CSR_GAIN, 16'd0,          1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h7FFF,       1'b1, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'(-20000),    1'b1, 20'sd0},
      '{ROW_WRITE,  CSR_GAIN, 16'hFFFF,       1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h7FFF,       1'b1, 20'sd262140},
      '{ROW_SAMPLE, NO_INDEX, 16'h8000,       1'b1, 20'(-262140)},
      '{ROW_SAMPLE, NO_INDEX, 16'd7,          1'b0, 20'sd0},
      // reversed axis; spare indexes must leave the settings alone
      '{ROW_WRITE,  CSR_REVERSE_AXIS, 16'hFFFF, 1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_GAIN, 16'd4096,       1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_SPARE_SIX, 16'h1234,  1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_SPARE_SEVEN, 16'hFFFF, 1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h7FFF,       1'b1, 20'(-16384)},
      '{ROW_SAMPLE, NO_INDEX, 16'h8000,       1'b1, 20'sd16384},
      // dead band around an offset trim, top bit of the dead zone word dropped
      '{ROW_WRITE,  CSR_REVERSE_AXIS, 16'hFFFE, 1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_TRIM_CENTER, 16'd1000, 1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_DEAD_ZONE, 16'h81F4,  1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'd1500,       1'b1, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'd500,        1'b1, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'd1501,       1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'd499,        1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h7FFF,       1'b1, 20'sd16384},
      '{ROW_SAMPLE, NO_INDEX, 16'h8000,       1'b1, 20'(-16384)},
      // widest dead band
      '{ROW_WRITE,  CSR_TRIM_CENTER, 16'd0,   1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_DEAD_ZONE, 16'h7FFF,  1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h8000,       1'b1, 20'(-16384)},
      '{ROW_SAMPLE, NO_INDEX, 16'h7FFF,       1'b1, 20'sd0},
      // crossed bounds with a zero span below the band
      '{ROW_WRITE,  CSR_RAW_MINIMUM, 16'd0,   1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_RAW_MAXIMUM, 16'(-1000), 1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_TRIM_CENTER, 16'd500, 1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_DEAD_ZONE, 16'd500,   1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'd12345,      1'b1, 20'(-16384)},
      // negative span
      '{ROW_WRITE,  CSR_TRIM_CENTER, 16'(-500), 1'b0, 20'sd0},
      '{ROW_WRITE,  CSR_DEAD_ZONE, 16'd0,     1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h8000,       1'b0, 20'sd0},
      '{ROW_SAMPLE, NO_INDEX, 16'h7FFF,       1'b0, 20'sd0}
   };

   stick_axis_deadzone_normalizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_raw_sample   (req_raw_sample),
      .rsp_strobe       (rsp_strobe),
      .rsp_scaled_value (rsp_scaled_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint q14_ratio(input longint num, input longint den);
      longint q;
      if (den == 0) return (num < 0) ? -UNITY_Q14 : UNITY_Q14;
      q = (num * UNITY_Q14) / den;
      if (q > UNITY_Q14) q = UNITY_Q14;
      if (q < -UNITY_Q14) q = -UNITY_Q14;
      return q;
   endfunction

   function automatic logic signed [SADN_OUT_W-1:0] predict_scaled(
      input logic signed [SADN_SAMPLE_W-1:0] raw);
      longint x, lo, hi, upper_edge, lower_edge, q, scaled;
      x = raw;
      lo = cfg_raw_min;
      hi = cfg_raw_max;
      upper_edge = longint'(cfg_trim) + longint'(cfg_dead_zone);
      lower_edge = longint'(cfg_trim) - longint'(cfg_dead_zone);
      // raise first, then lower: crossed bounds end at the maximum
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      q = 0;
      if (x > upper_edge) q = q14_ratio(x - upper_edge, hi - upper_edge);
      else if (x < lower_edge) q = q14_ratio(x - lower_edge, lower_edge - lo);
      if (cfg_reverse) q = -q;
      if (q < -UNITY_Q14) q = -UNITY_Q14;
      if (q > UNITY_Q14) q = UNITY_Q14;
      scaled = (q * longint'(cfg_gain)) / UNITY_Q12;
      return scaled[SADN_OUT_W-1:0];
   endfunction

   function automatic void reset_settings();
      cfg_raw_min   = 16'h8000;
      cfg_raw_max   = 16'h7FFF;
      cfg_trim      = '0;
      cfg_dead_zone = '0;
      cfg_reverse   = 1'b0;
      cfg_gain      = 16'd4096;
   endfunction

   // Leaves the write enable high; the caller drops it after the last write.
   task automatic write_register(input logic [SADN_CSR_IDX_W-1:0] index,
                                 input logic [SADN_SAMPLE_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_RAW_MINIMUM:  cfg_raw_min   = data;
         CSR_RAW_MAXIMUM:  cfg_raw_max   = data;
         CSR_TRIM_CENTER:  cfg_trim      = data;
         CSR_DEAD_ZONE:    cfg_dead_zone = data[SADN_DZ_W-1:0];
         CSR_REVERSE_AXIS: cfg_reverse   = data[0];
         CSR_GAIN:         cfg_gain      = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [SADN_SAMPLE_W-1:0] raw, input bit checked,
                              input logic signed [SADN_OUT_W-1:0] want);
      start          <= 1'b1;
      req_raw_sample <= raw;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_scaled.push_back(checked ? want : predict_scaled(raw));
   endtask

   task automatic wait_for_results();
      while (pending_scaled.size() != 0) @(posedge clock);
   endtask

   function automatic logic [SADN_SAMPLE_W-1:0] pick_bound();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'd0;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic load_random_settings(input bit ordered);
      int lo, hi, mid, t, room, band;
      logic [SADN_SAMPLE_W-1:0] gain_word;
      if (ordered) begin
         if ($urandom_range(0, 1) == 1) begin
            mid = int'($urandom_range(0, 60000)) - 30000;
            lo  = mid - int'($urandom_range(0, 2000));
            hi  = mid + int'($urandom_range(0, 2000));
         end else begin
            lo  = int'($urandom_range(0, 65535)) - 32768;
            mid = int'($urandom_range(0, 65535)) - 32768;
            hi  = int'($urandom_range(0, 65535)) - 32768;
            if (lo > mid) begin t = lo; lo = mid; mid = t; end
            if (mid > hi) begin t = mid; mid = hi; hi = t; end
            if (lo > mid) begin t = lo; lo = mid; mid = t; end
         end
         if ($urandom_range(0, 3) == 0) lo = -32768;
         if ($urandom_range(0, 3) == 0) hi = 32767;
         room = (mid - lo < hi - mid) ? mid - lo : hi - mid;
         case ($urandom_range(0, 3))
            0: band = 0;
            1: band = room;
            default: band = int'($urandom_range(0, room));
         endcase
         write_register(CSR_RAW_MINIMUM, 16'(lo));
         write_register(CSR_RAW_MAXIMUM, 16'(hi));
         write_register(CSR_TRIM_CENTER, 16'(mid));
         write_register(CSR_DEAD_ZONE, {1'($urandom_range(0, 1)), 15'(band)});
      end else begin
         write_register(CSR_RAW_MINIMUM, pick_bound());
         write_register(CSR_RAW_MAXIMUM, pick_bound());
         write_register(CSR_TRIM_CENTER, pick_bound());
         case ($urandom_range(0, 2))
            0: write_register(CSR_DEAD_ZONE, 16'd0);
            1: write_register(CSR_DEAD_ZONE, 16'hFFFF);
            default: write_register(CSR_DEAD_ZONE, 16'($urandom_range(0, 65535)));
         endcase
      end
      write_register(CSR_REVERSE_AXIS, 16'($urandom_range(0, 65535)));
      case ($urandom_range(0, 5))
         0: gain_word = 16'd0;
         1: gain_word = 16'hFFFF;
         2: gain_word = 16'd4096;
         default: gain_word = 16'($urandom_range(0, 65535));
      endcase
      write_register(CSR_GAIN, gain_word);
   endtask

   // Mix samples at the clamp bounds and band edges of the current settings with extremes and random values.
   function automatic logic [SADN_SAMPLE_W-1:0] pick_sample();
      int lo, hi, centre, band, offset;
      lo     = cfg_raw_min;
      hi     = cfg_raw_max;
      centre = cfg_trim;
      band   = int'(cfg_dead_zone);
      offset = int'($urandom_range(0, 4)) - 2;
      case ($urandom_range(0, 9))
         0, 1, 2: return 16'($urandom_range(0, 65535));
         3: return 16'(lo + offset);
         4: return 16'(hi + offset);
         5: return 16'(centre + band + offset);
         6: return 16'(centre - band + offset);
         7: return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
         default: begin
            if (lo <= hi) return 16'(lo + int'($urandom_range(0, hi - lo)));
            return 16'(hi + offset);
         end
      endcase
   endfunction

   task automatic run_phase(input int count, input int gap_pct);
      for (int n = 0; n < count; n++) begin
         if (int'($urandom_range(0, 99)) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         send_sample(pick_sample(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      logic signed [SADN_OUT_W-1:0] oldest;
      if (!reset && rsp_strobe) begin
         if (pending_scaled.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: unexpected beat, expected none, got %0d", $time,
                        rsp_scaled_value);
            mismatches++;
         end else begin
            oldest = pending_scaled.pop_front();
            if (rsp_scaled_value !== oldest) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: scaled_value mismatch, expected %0d, got %0d", $time,
                           oldest, rsp_scaled_value);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d beats outstanding", $time,
                  pending_scaled.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      dir_row_type row;
      bit          writing;
      int          gap_pct;
      reset_settings();
      writing = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_WRITE) begin
            if (!writing) begin
               start <= 1'b0;
               wait_for_results();
               writing = 1'b1;
            end
            write_register(row.index, row.value);
         end else begin
            if (writing) csr_write_enable <= 1'b0;
            writing = 1'b0;
            send_sample(row.value, row.checked, row.want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         start <= 1'b0;
         wait_for_results();
         load_random_settings(phase % 4 != 3);
         csr_write_enable <= 1'b0;
         // no idling in the closing phases
         if (phase >= RANDOM_PHASES - 2) gap_pct = 0;
         else begin
            case ($urandom_range(0, 3))
               0: gap_pct = 0;
               1: gap_pct = 15;
               2: gap_pct = 40;
               default: gap_pct = 70;
            endcase
         end
         run_phase(ITEMS_PER_PHASE, gap_pct);
      end

      start <= 1'b0;
      wait_for_results();
      // hold a little longer to catch stray beats
      repeat (SADN_LATENCY + 4) @(posedge clock);
      if (mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

[stick_axis_deadzone_normalizer.f]
+incdir+src
src/sadn_pkg.sv
src/sadn_front.sv
src/sadn_div_cell.sv
src/sadn_back.sv
src/stick_axis_deadzone_normalizer.sv
dv/testbench.sv
